>>> rtl/core/dtwca_pkg.sv
// Package: shared constants and types of the DTW cost accumulator.
package dtwca_pkg;

    // Geometry limits
    localparam int unsigned MAX_ROWS    = 1024;
    localparam int unsigned MAX_COLUMNS = 1024;
    localparam int unsigned ROW_W       = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int unsigned COL_W       = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

    // Field widths
    localparam int unsigned CNT_W   = 11;
    localparam int unsigned DIST_W  = 16;
    localparam int unsigned COST_W  = 32;
    localparam int unsigned CIDX_W  = 1;

    // Configuration register indexes
    localparam logic [CIDX_W-1:0] REG_ROW_COUNT    = 1'b0;
    localparam logic [CIDX_W-1:0] REG_COLUMN_COUNT = 1'b1;

    typedef logic [COST_W-1:0] t_cost;

    // Cell word held in the compute stage
    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic [ROW_W-1:0]  row;
        logic              first_row;
        logic              first_col;
        logic              last_cell;
    } t_cell;

endpackage

>>> rtl/core/dtwca_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dtwca_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                 i_wdata,
    input  logic                             i_re,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_raddr,
    output logic [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port; read returns the old contents on a same-address collision
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

>>> rtl/core/dtw_cost_accumulator_unit.sv
// Top level: streamed DTW cost accumulator with a line store of the previous column.
// Throughput: one distance word per cycle, sustained, including across column ends;
// a last cell stalls only while the previous total still waits in the result register.
// Result path: the last word enters the compute stage at its accept, and its total moves into the result register
// when that cell fires. The line store read overlaps the accept; the add-min runs in the next stage.
// Reset: synchronous, active low; counts go to 1, positions and flags clear, line store kept.
module dtw_cost_accumulator_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // distance channel
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [dtwca_pkg::DIST_W-1:0]      i_distance,
    // result channel
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [dtwca_pkg::COST_W-1:0]      o_warp_cost,
    output logic                              o_saturated,
    // configuration channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [dtwca_pkg::CIDX_W-1:0]      i_cfg_index,
    input  logic [dtwca_pkg::CNT_W-1:0]       i_cfg_data
);

    localparam int unsigned ROW_W  = dtwca_pkg::ROW_W;
    localparam int unsigned COL_W  = dtwca_pkg::COL_W;
    localparam int unsigned CNT_W  = dtwca_pkg::CNT_W;
    localparam int unsigned COST_W = dtwca_pkg::COST_W;

    // Configuration registers
    logic [CNT_W-1:0] r_row_count, r_col_count;
    logic             w_cfg_we;

    // Position of the next cell
    logic [ROW_W-1:0] r_row, n_row;
    logic [COL_W-1:0] r_col, n_col;

    // Compute stage
    logic                 r_s1_valid;
    dtwca_pkg::t_cell     r_s1, n_s1;
    logic                 r_fwd;
    dtwca_pkg::t_cost     r_fwd_data;
    dtwca_pkg::t_cost     r_diag, r_upper;
    logic                 r_clamp;

    // Output register
    logic                 r_out_valid;
    dtwca_pkg::t_cost     r_out_cost;
    logic                 r_out_sat;

    logic                 w_accept, w_s1_fire, w_out_free;
    logic [ROW_W-1:0]     w_last_row;
    logic [COL_W-1:0]     w_last_col;
    logic                 w_is_last_row, w_is_last_col;
    dtwca_pkg::t_cost     w_rdata, w_left, w_diag, w_up, w_best, w_cost;
    logic [COST_W:0]      w_sum;
    logic                 w_ovf;

    // Effective last indexes: zero acts as one, oversize acts as the maximum
    always_comb begin
        logic [CNT_W-1:0] rows_eff, cols_eff;
        rows_eff = r_row_count;
        cols_eff = r_col_count;
        if (r_row_count == '0) begin
            rows_eff = CNT_W'(1);
        end else if (32'(r_row_count) > dtwca_pkg::MAX_ROWS) begin
            rows_eff = CNT_W'(dtwca_pkg::MAX_ROWS);
        end
        if (r_col_count == '0) begin
            cols_eff = CNT_W'(1);
        end else if (32'(r_col_count) > dtwca_pkg::MAX_COLUMNS) begin
            cols_eff = CNT_W'(dtwca_pkg::MAX_COLUMNS);
        end
        w_last_row = ROW_W'(rows_eff - CNT_W'(1));
        w_last_col = COL_W'(cols_eff - CNT_W'(1));
    end

    // Handshakes
    assign w_cfg_we    = i_cfg_valid;
    assign o_cfg_ready = 1'b1;
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_s1_fire   = r_s1_valid && (!r_s1.last_cell || w_out_free);
    assign o_in_ready  = !r_s1_valid || w_s1_fire;
    assign w_accept    = i_in_valid && o_in_ready;

    // Position walk, row index fastest
    assign w_is_last_row = (r_row == w_last_row);
    assign w_is_last_col = (r_col == w_last_col);

    always_comb begin
        n_row = r_row;
        n_col = r_col;
        if (w_accept) begin
            if (!w_is_last_row) begin
                n_row = r_row + ROW_W'(1);
            end else if (!w_is_last_col) begin
                n_row = '0;
                n_col = r_col + COL_W'(1);
            end else begin
                n_row = '0;
                n_col = '0;
            end
        end
    end

    always_comb begin
        n_s1.distance  = i_distance;
        n_s1.row       = r_row;
        n_s1.first_row = (r_row == '0);
        n_s1.first_col = (r_col == '0);
        n_s1.last_cell = w_is_last_row && w_is_last_col;
    end

    // Line store of the previous column
    dtwca_ram #(
        .WIDTH (COST_W),
        .DEPTH (dtwca_pkg::MAX_ROWS)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (w_s1_fire),
        .i_waddr (r_s1.row),
        .i_wdata (w_cost),
        .i_re    (w_accept),
        .i_raddr (r_row),
        .o_rdata (w_rdata)
    );

    // Add-min: neighbours with zero padding, saturating sum
    always_comb begin
        w_left = r_s1.first_col ? '0 : (r_fwd ? r_fwd_data : w_rdata);
        w_diag = (r_s1.first_row || r_s1.first_col) ? '0 : r_diag;
        w_up   = r_s1.first_row ? '0 : r_upper;
        w_best = (w_up < w_diag) ? w_up : w_diag;
        if (w_left < w_best) begin
            w_best = w_left;
        end
        w_sum  = {1'b0, w_best} + (COST_W + 1)'(r_s1.distance);
        w_ovf  = w_sum[COST_W];
        w_cost = w_ovf ? '1 : w_sum[COST_W-1:0];
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count <= CNT_W'(1);
            r_col_count <= CNT_W'(1);
            r_row       <= '0;
            r_col       <= '0;
            r_s1_valid  <= 1'b0;
            r_fwd       <= 1'b0;
            r_clamp     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_cfg_we) begin
                unique case (i_cfg_index)
                    dtwca_pkg::REG_ROW_COUNT:    r_row_count <= i_cfg_data;
                    dtwca_pkg::REG_COLUMN_COUNT: r_col_count <= i_cfg_data;
                    default: ;
                endcase
                r_row   <= '0;
                r_col   <= '0;
                r_clamp <= 1'b0;
            end else begin
                r_row <= n_row;
                r_col <= n_col;
                if (w_s1_fire) begin
                    r_clamp <= r_s1.last_cell ? 1'b0 : (r_clamp | w_ovf);
                end
            end
            if (w_accept) begin
                r_s1_valid <= 1'b1;
                r_fwd      <= w_s1_fire && (r_s1.row == r_row);
            end else if (w_s1_fire) begin
                r_s1_valid <= 1'b0;
                r_fwd      <= 1'b0;
            end
            if (w_s1_fire && r_s1.last_cell) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1       <= n_s1;
            r_fwd_data <= w_cost;
        end
        if (w_s1_fire) begin
            r_diag  <= w_left;
            r_upper <= w_cost;
            if (r_s1.last_cell) begin
                r_out_cost <= w_cost;
                r_out_sat  <= r_clamp | w_ovf;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_warp_cost = r_out_cost;
    assign o_saturated = r_out_sat;

    // Checks
    a_stall_only_on_full_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !w_s1_fire) |-> (r_s1.last_cell && r_out_valid && !i_out_ready))
        else $error("compute stage stalled without a blocked result");

    a_result_from_last_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(w_s1_fire && r_s1.last_cell))
        else $error("result raised without a last cell");

    a_row_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_row <= w_last_row) && (r_col <= w_last_col))
        else $error("cell position beyond matrix bounds");

    a_forward_needs_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd |-> r_s1_valid)
        else $error("forwarded line word without a cell in flight");

endmodule
